### src/hpbi_pkg.sv
// Shared types and constants for the half-pel block interpolator.
`default_nettype none

package hpbi_pkg;

	// Block geometry
	localparam int BLK_DIM    = 8;
	localparam int ROW_PIXELS = BLK_DIM + 1;

	// Interpolation mode codes (the unused code behaves as diagonal)
	localparam logic [1:0] MODE_H  = 2'd0;
	localparam logic [1:0] MODE_V  = 2'd1;
	localparam logic [1:0] MODE_HV = 2'd2;

	// Configuration register indexes
	localparam logic REG_INTERP_MODE   = 1'b0;
	localparam logic REG_ROUNDING_MODE = 1'b1;

	typedef logic [7:0] pix_t;
	typedef logic [3:0] row_cnt_t;

	// One source row
	typedef struct packed {
		logic start_of_block;
		pix_t pixel_0;
		pix_t pixel_1;
		pix_t pixel_2;
		pix_t pixel_3;
		pix_t pixel_4;
		pix_t pixel_5;
		pix_t pixel_6;
		pix_t pixel_7;
		pix_t pixel_8;
	} in_word_t;

	// One interpolated row
	typedef struct packed {
		pix_t out_0;
		pix_t out_1;
		pix_t out_2;
		pix_t out_3;
		pix_t out_4;
		pix_t out_5;
		pix_t out_6;
		pix_t out_7;
		logic last_row;
	} out_word_t;

endpackage

`default_nettype wire

### src/hpbi_if.sv
// Valid/ready stream interfaces for source rows and interpolated rows.
`default_nettype none

interface hpbi_in_if import hpbi_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hpbi_out_if import hpbi_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/halfpel_block_interpolator_core.sv
// Half-pel 8x8 block interpolator: one source row in, at most one result row out.
//
// Channels: row_in carries one source row of nine pixels and a block-start
// flag per word; row_out carries eight interpolated pixels and a last-row
// flag per word. Both use valid/ready; a word moves when both are high.
// Configuration (interp_mode, rounding_mode) is written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce. Each row samples it when accepted.
// A result word passes the input stage register, then the result register,
// before it is valid on row_out; a stalled receiver can hold it in between.
// Throughput: one row per cycle while the receiver does not stall; the averaging
// adders between the two registers are the only logic on the data path.
// In vertical and diagonal modes the first row of a block only loads the
// previous-row store and yields no word, so such a block takes nine rows.
// Reset clears both stages, the row count (block start pending), the
// previous-row store and the configuration.
// When the receiver stalls, the result register holds its word, the input
// stage fills behind it, and row_in.ready drops once both are occupied.
`default_nettype none

module halfpel_block_interpolator_core import hpbi_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_index,
	input  wire logic [1:0] cfg_wdata,
	hpbi_in_if.sink     row_in,
	hpbi_out_if.source  row_out
);

	// Configuration and block state
	logic [1:0] interp_mode_q;
	logic       rounding_mode_q;
	pix_t       prev_row_q [ROW_PIXELS];
	row_cnt_t   rows_seen_q;

	// Input stage
	logic       valid_s1;
	pix_t       cur_s1  [ROW_PIXELS];
	pix_t       prev_s1 [ROW_PIXELS];
	logic [1:0] mode_s1;
	logic       round_s1;
	logic       last_s1;

	// Result stage
	logic       valid_s2;
	out_word_t  word_s2;

	// Accept-time control
	pix_t       cur_row [ROW_PIXELS];
	logic       in_acc;
	logic       adv_s1;
	logic [1:0] mode_eff;
	row_cnt_t   k_row;
	logic       load_only;
	logic       last_row;

	// Column results
	pix_t       avg [BLK_DIM];

	// Unpack the source row
	assign cur_row[0] = row_in.data.pixel_0;
	assign cur_row[1] = row_in.data.pixel_1;
	assign cur_row[2] = row_in.data.pixel_2;
	assign cur_row[3] = row_in.data.pixel_3;
	assign cur_row[4] = row_in.data.pixel_4;
	assign cur_row[5] = row_in.data.pixel_5;
	assign cur_row[6] = row_in.data.pixel_6;
	assign cur_row[7] = row_in.data.pixel_7;
	assign cur_row[8] = row_in.data.pixel_8;

	// Handshake: stage one advances when the result register is free or draining
	assign adv_s1       = valid_s1 && (!valid_s2 || row_out.ready);
	assign row_in.ready = !valid_s1 || adv_s1;
	assign in_acc       = row_in.valid && row_in.ready;

	// Row position, mode folding and end-of-block decision
	always_comb begin
		mode_eff  = (interp_mode_q == MODE_H) ? MODE_H :
		            (interp_mode_q == MODE_V) ? MODE_V : MODE_HV;
		k_row     = row_in.data.start_of_block ? '0 : rows_seen_q;
		load_only = (mode_eff != MODE_H) && (k_row == '0);
		if (mode_eff == MODE_H) begin
			last_row = (k_row >= row_cnt_t'(BLK_DIM - 1));
		end else begin
			last_row = (k_row >= row_cnt_t'(BLK_DIM));
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q   <= MODE_H;
			rounding_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERP_MODE:   interp_mode_q   <= cfg_wdata;
				REG_ROUNDING_MODE: rounding_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Advance the row count and refresh the previous-row store on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_seen_q <= '0;
			for (int i = 0; i < ROW_PIXELS; i++) begin
				prev_row_q[i] <= '0;
			end
		end else if (in_acc) begin
			if (load_only) begin
				rows_seen_q <= row_cnt_t'(1);
			end else if (last_row) begin
				rows_seen_q <= '0;
			end else begin
				rows_seen_q <= k_row + row_cnt_t'(1);
			end
			prev_row_q <= cur_row;
		end
	end

	// Stage one valid: a load-only row leaves the stage empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= !load_only;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the current and previous rows with the sampled settings
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1   <= cur_row;
			prev_s1  <= prev_row_q;
			mode_s1  <= mode_eff;
			round_s1 <= rounding_mode_q;
			last_s1  <= last_row;
		end
	end

	// Average each column
	always_comb begin
		logic [8:0] sum2;
		logic [9:0] sum4;
		for (int i = 0; i < BLK_DIM; i++) begin
			sum2 = '0;
			sum4 = '0;
			case (mode_s1)
				MODE_H: begin
					sum2 = 9'(cur_s1[i]) + 9'(cur_s1[i+1]) + 9'(1) - 9'(round_s1);
					avg[i] = sum2[8:1];
				end
				MODE_V: begin
					sum2 = 9'(prev_s1[i]) + 9'(cur_s1[i]) + 9'(1) - 9'(round_s1);
					avg[i] = sum2[8:1];
				end
				default: begin
					sum4 = 10'(prev_s1[i]) + 10'(prev_s1[i+1]) + 10'(cur_s1[i])
					     + 10'(cur_s1[i+1]) + 10'(2) - 10'(round_s1);
					avg[i] = sum4[9:2];
				end
			endcase
		end
	end

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (row_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s2.out_0    <= avg[0];
			word_s2.out_1    <= avg[1];
			word_s2.out_2    <= avg[2];
			word_s2.out_3    <= avg[3];
			word_s2.out_4    <= avg[4];
			word_s2.out_5    <= avg[5];
			word_s2.out_6    <= avg[6];
			word_s2.out_7    <= avg[7];
			word_s2.last_row <= last_s1;
		end
	end

	assign row_out.valid = valid_s2;
	assign row_out.data  = word_s2;

	// The row count never runs past one block
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_seen_q <= row_cnt_t'(BLK_DIM))
		else $error("row count beyond block size");

	// A load-only row must not reach the input stage
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && load_only) |=> !valid_s1)
		else $error("load-only row produced a result");

	// Both stages full and stalled: no new word may be taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !row_out.ready) |-> !row_in.ready)
		else $error("row taken while pipeline full");

	// A forced start in vertical or diagonal mode leaves one row counted
	a_forced_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && row_in.data.start_of_block && (mode_eff != MODE_H))
		|=> (rows_seen_q == row_cnt_t'(1)))
		else $error("forced block start not counted as first row");

endmodule

`default_nettype wire

### sim/hpbi_row_checker.sv
// Row checker for the half-pel block interpolator: predicts each result word and compares it.
module hpbi_row_checker import hpbi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_wdata,
	hpbi_in_if         row_in,
	hpbi_out_if        row_out,
	output int         mismatches,
	output int         rows_owed
);

	// Own copy of the block state and configuration
	pix_t      prev_row [ROW_PIXELS];
	row_cnt_t  rows_seen;
	logic [1:0] mode_reg;
	logic      round_down;
	out_word_t owed_rows [$];
	int        rows_checked;

	// Work out the word a source row gives, if any, and advance the state
	task automatic interpolate_row(input in_word_t w);
		pix_t       cur [ROW_PIXELS];
		row_cnt_t   k;
		logic [1:0] m;
		logic [9:0] acc;
		pix_t       res [BLK_DIM];
		logic       last;
		cur = '{w.pixel_0, w.pixel_1, w.pixel_2, w.pixel_3, w.pixel_4,
			w.pixel_5, w.pixel_6, w.pixel_7, w.pixel_8};
		k = w.start_of_block ? row_cnt_t'(0) : rows_seen;
		// the spare mode code acts as diagonal
		m = (mode_reg == MODE_H || mode_reg == MODE_V) ? mode_reg : MODE_HV;
		if (m != MODE_H && k == 0) begin
			// first row of a vertical or diagonal block only loads the store
			prev_row = cur;
			rows_seen = 1;
			return;
		end
		for (int i = 0; i < BLK_DIM; i++) begin
			case (m)
				MODE_H: begin
					acc = 10'(cur[i]) + 10'(cur[i+1]) + 10'd1 - 10'(round_down);
					res[i] = pix_t'(acc >> 1);
				end
				MODE_V: begin
					acc = 10'(prev_row[i]) + 10'(cur[i]) + 10'd1 - 10'(round_down);
					res[i] = pix_t'(acc >> 1);
				end
				default: begin
					acc = 10'(prev_row[i]) + 10'(prev_row[i+1]) + 10'(cur[i])
						+ 10'(cur[i+1]) + 10'd2 - 10'(round_down);
					res[i] = pix_t'(acc >> 2);
				end
			endcase
		end
		last = (m == MODE_H) ? (k >= BLK_DIM - 1) : (k >= BLK_DIM);
		owed_rows.push_back(out_word_t'{res[0], res[1], res[2], res[3], res[4], res[5],
			res[6], res[7], last});
		prev_row = cur;
		rows_seen = last ? row_cnt_t'(0) : row_cnt_t'(k + 1);
	endtask

	// Compare a result word with the oldest one owed
	task automatic check_row(input out_word_t got);
		out_word_t e;
		pix_t      ep [BLK_DIM];
		pix_t      gp [BLK_DIM];
		logic      bad;
		if (owed_rows.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result word: pixels %h last %b", got[64:1],
					got.last_row);
			mismatches++;
			return;
		end
		e = owed_rows.pop_front();
		ep = '{e.out_0, e.out_1, e.out_2, e.out_3, e.out_4, e.out_5, e.out_6, e.out_7};
		gp = '{got.out_0, got.out_1, got.out_2, got.out_3, got.out_4, got.out_5,
			got.out_6, got.out_7};
		bad = (e.last_row !== got.last_row);
		for (int i = 0; i < BLK_DIM; i++)
			if (ep[i] !== gp[i])
				bad = 1'b1;
		if (bad) begin
			if (mismatches < 10)
				$display("word %0d mismatch: expected pixels %h last %b, got pixels %h last %b",
					rows_checked, e[64:1], e.last_row, got[64:1], got.last_row);
			mismatches++;
		end
		rows_checked++;
	endtask

	// Track configuration writes, accepted rows and result words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (prev_row[i])
				prev_row[i] = '0;
			rows_seen = '0;
			mode_reg = MODE_H;
			round_down = 1'b0;
			owed_rows.delete();
			mismatches = 0;
			rows_checked = 0;
			rows_owed = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_INTERP_MODE)
					mode_reg = cfg_wdata;
				else
					round_down = cfg_wdata[0];
			end
			if (row_in.valid && row_in.ready)
				interpolate_row(row_in.data);
			if (row_out.valid && row_out.ready)
				check_row(row_out.data);
			rows_owed = owed_rows.size();
		end
	end

endmodule

### sim/tb_top.sv
// Testbench top for the half-pel block interpolator: clock, reset, row stimulus and verdict.
module tb_top import hpbi_pkg::*; ();

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int         CYCLE_LIMIT = 100000;
	localparam int         PHASES = 9;
	localparam int         PHASE_ROWS = 100;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [1:0] cfg_wdata;
	logic       calm;
	int         mismatches;
	int         rows_owed;
	int         cycle_count;

	hpbi_in_if  row_in_ch ();
	hpbi_out_if row_out_ch ();

	halfpel_block_interpolator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.row_in    (row_in_ch),
		.row_out   (row_out_ch)
	);

	hpbi_row_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.row_in     (row_in_ch),
		.row_out    (row_out_ch),
		.mismatches (mismatches),
		.rows_owed  (rows_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Row of two alternating pixel values
	function automatic in_word_t pattern_row(logic sob, pix_t a, pix_t b);
		return '{sob, a, b, a, b, a, b, a, b, a};
	endfunction

	// Row of random pixels, now and then pinned to the extremes
	function automatic in_word_t random_row(logic sob);
		pix_t p [ROW_PIXELS];
		foreach (p[i])
			p[i] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
				: pix_t'($urandom);
		return '{sob, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
	endfunction

	// Offer one row after a random gap and hold it until taken; call at a falling edge
	task automatic send_row(input in_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			row_in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_in_ch.data <= w;
		row_in_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!row_in_ch.ready);
		@(negedge clk);
	endtask

	// Stop sending and wait for every owed word, then let the pipeline settle
	task automatic drain();
		row_in_ch.valid <= 1'b0;
		@(negedge clk);
		while (rows_owed != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic set_config(input logic [1:0] mode, input logic rnd);
		cfg_we <= 1'b1;
		cfg_index <= REG_INTERP_MODE;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_index <= REG_ROUNDING_MODE;
		cfg_wdata <= {1'b0, rnd};
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: stall a random number of cycles before each word
	initial begin
		int stall;
		row_out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				row_out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			row_out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!row_out_ch.valid);
			@(negedge clk);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		logic [1:0] modes [4];
		logic [1:0] mode;
		logic       sob;
		int         sent;
		int         block_rows;
		modes = '{MODE_H, MODE_V, MODE_HV, MODE_SPARE};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INTERP_MODE;
		cfg_wdata = '0;
		calm = 1'b0;
		row_in_ch.valid = 1'b0;
		row_in_ch.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Horizontal, round half up: extremes, then a forced start part way through
		set_config(MODE_H, 1'b0);
		send_row(pattern_row(1'b0, 8'h00, 8'h00));
		send_row(pattern_row(1'b0, 8'hff, 8'hff));
		send_row(pattern_row(1'b0, 8'hff, 8'h00));
		send_row(pattern_row(1'b0, 8'h01, 8'h00));
		send_row(pattern_row(1'b1, 8'h80, 8'h7f));
		send_row(pattern_row(1'b0, 8'h00, 8'h01));
		send_row(pattern_row(1'b0, 8'hfe, 8'hff));
		drain();

		// Vertical, round down, switched in mid-block: no load row
		set_config(MODE_V, 1'b1);
		send_row(pattern_row(1'b0, 8'hff, 8'hff));
		send_row(pattern_row(1'b0, 8'h00, 8'h01));
		drain();

		// Spare mode code behaves as diagonal; forced start loads the store only
		set_config(MODE_SPARE, 1'b0);
		send_row(pattern_row(1'b1, 8'hff, 8'hff));
		send_row(pattern_row(1'b0, 8'hff, 8'hff));
		send_row(pattern_row(1'b0, 8'h00, 8'h01));
		drain();

		// Diagonal, round down
		set_config(MODE_HV, 1'b1);
		send_row(pattern_row(1'b0, 8'hff, 8'h00));
		send_row(pattern_row(1'b0, 8'h01, 8'h01));
		drain();

		// Random phases of mostly well-formed blocks, with stray forced starts
		for (int phase = 0; phase < PHASES; phase++) begin
			mode = modes[phase % 4];
			set_config(mode, 1'((phase / 4 + phase) % 2));
			calm = (phase % 3 == 1);
			sent = 0;
			while (sent < PHASE_ROWS) begin
				block_rows = (mode == MODE_H) ? BLK_DIM : BLK_DIM + 1;
				for (int r = 0; r < block_rows && sent < PHASE_ROWS; r++) begin
					sob = (r == 0) ? 1'($urandom_range(0, 1))
						: ($urandom_range(0, 15) == 0);
					send_row(random_row(sob));
					sent++;
				end
			end
			drain();
		end
		calm = 1'b0;

		repeat (8) @(negedge clk);
		if (mismatches == 0 && rows_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
